FILE: rtl/bounded_indexed_list_engine_macros.svh
// Assertion helpers used by the RTL.
`ifndef BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define BILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define BILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/bile_pkg.sv
`default_nettype none

package bile_pkg;

    localparam int FUNC_W           = 4;
    localparam int VAL_W            = 32;
    localparam int POS_W            = 7;
    localparam int CAPACITY_MAX_DEF = 64;
    localparam int DATA_WIDTH_DEF   = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 4'd0,
        FN_INS_BACK  = 4'd1,
        FN_INS_AT    = 4'd2,
        FN_RM_FRONT  = 4'd3,
        FN_RM_BACK   = 4'd4,
        FN_RM_AT     = 4'd5,
        FN_SEARCH    = 4'd6,
        FN_SELECT    = 4'd7,
        FN_REPLACE   = 4'd8
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_WR,
        S_PUT,
        S_CMP,
        S_SEL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/bile_ram.sv
`default_nettype none

module bile_ram #(
    parameter int DEPTH = bile_pkg::CAPACITY_MAX_DEF,
    parameter int DW    = bile_pkg::DATA_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/bounded_indexed_list_engine.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------------
// request  | in        | i_in_valid / o_in_ready   | i_func, i_item_value, i_position
// result   | out       | o_out_valid / i_out_ready | o_ok, o_found_index, o_read_value,
//          |           |                           | o_entry_count, o_is_empty, o_is_full
//
// One request at a time.
// Each entry moved or compared passes through a read state and then a write or compare state in the store.
// Select reads once and latches the value, replace writes once, and a refused request goes straight to the result.
// Reset clears the count and the handshake state; the store needs no clearing pass.
// Ready returns with the result beat; a stalled consumer holds the next request in its last cycle.
`default_nettype none

`include "bounded_indexed_list_engine_macros.svh"

module bounded_indexed_list_engine #(
    parameter int CAPACITY_MAX = bile_pkg::CAPACITY_MAX_DEF,
    parameter int DATA_WIDTH   = bile_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic        [bile_pkg::FUNC_W-1:0] i_func,
    input  wire logic signed [bile_pkg::VAL_W-1:0]  i_item_value,
    input  wire logic        [bile_pkg::POS_W-1:0]  i_position,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_ok,
    output logic             [bile_pkg::POS_W-1:0]  o_found_index,
    output logic signed      [bile_pkg::VAL_W-1:0]  o_read_value,
    output logic             [bile_pkg::POS_W-1:0]  o_entry_count,
    output logic                                    o_is_empty,
    output logic                                    o_is_full
);

    localparam int AW = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
    localparam int CW = $clog2(CAPACITY_MAX + 1);
    localparam int PW = bile_pkg::POS_W;
    localparam int XW = (CW > PW) ? CW : PW;
    localparam int EW = 64;
    localparam int VW = bile_pkg::VAL_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY_MAX);

    bile_pkg::t_state r_state, n_state;

    logic [CW-1:0]              r_count, n_count;
    logic                       r_o_valid, n_o_valid;

    logic [bile_pkg::FUNC_W-1:0] r_func, n_func;
    logic [DATA_WIDTH-1:0]      r_val, n_val;
    logic [PW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_tgt, n_tgt;
    logic                       r_ok_w, n_ok_w;
    logic [CW-1:0]              r_found_w, n_found_w;
    logic [VW-1:0]              r_rd_w, n_rd_w;

    logic                       r_o_ok;
    logic [PW-1:0]              r_o_found;
    logic [VW-1:0]              r_o_rd;
    logic [PW-1:0]              r_o_count;
    logic                       r_o_empty;
    logic                       r_o_full;
    logic                       out_load;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [DATA_WIDTH-1:0]      ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [DATA_WIDTH-1:0]      ram_rdata;

    logic signed [EW-1:0]       wv_ext;
    logic signed [EW-1:0]       rd_ext;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              cnt_x;
    logic [XW-1:0]              tgt_x;
    logic                       is_ins;
    logic                       is_scan;
    logic [CW-1:0]              step_k;
    logic [CW-1:0]              idx_step;

    assign wv_ext = EW'(i_item_value);
    assign rd_ext = EW'(signed'(ram_rdata));
    assign pos_x  = XW'(r_pos);
    assign cnt_x  = XW'(r_count);

    assign is_ins  = (r_func == bile_pkg::FN_INS_FRONT) || (r_func == bile_pkg::FN_INS_BACK)
                  || (r_func == bile_pkg::FN_INS_AT);
    assign is_scan = (r_func == bile_pkg::FN_SEARCH) || (r_func == bile_pkg::FN_SELECT);

    // shared index unit: down for inserts, up for everything else
    assign step_k   = is_ins ? {CW{1'b1}} : CW'(1);
    assign idx_step = r_idx + step_k;

    bile_ram #(
        .DEPTH (CAPACITY_MAX),
        .DW    (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_func    = r_func;
        n_val     = r_val;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_tgt     = r_tgt;
        n_ok_w    = r_ok_w;
        n_found_w = r_found_w;
        n_rd_w    = r_rd_w;
        tgt_x     = '0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = is_scan ? r_idx[AW-1:0] : idx_step[AW-1:0];
        o_in_ready = (r_state == bile_pkg::S_IDLE);

        case (r_state)
            bile_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = i_func;
                    n_val     = wv_ext[DATA_WIDTH-1:0];
                    n_pos     = i_position;
                    n_ok_w    = 1'b0;
                    n_found_w = '0;
                    n_rd_w    = '0;
                    n_state   = bile_pkg::S_DECODE;
                end
            end
            bile_pkg::S_DECODE: begin
                n_state = bile_pkg::S_DONE;
                case (r_func)
                    bile_pkg::FN_INS_FRONT, bile_pkg::FN_INS_BACK, bile_pkg::FN_INS_AT: begin
                        if (r_func == bile_pkg::FN_INS_FRONT) begin
                            tgt_x = '0;
                        end else if (r_func == bile_pkg::FN_INS_BACK) begin
                            tgt_x = cnt_x;
                        end else begin
                            tgt_x = pos_x;
                        end
                        if (r_count != CAP && tgt_x <= cnt_x) begin
                            n_tgt   = CW'(tgt_x);
                            n_idx   = r_count;
                            n_state = (cnt_x > tgt_x) ? bile_pkg::S_RD : bile_pkg::S_PUT;
                        end
                    end
                    bile_pkg::FN_RM_FRONT, bile_pkg::FN_RM_BACK, bile_pkg::FN_RM_AT: begin
                        if (r_func == bile_pkg::FN_RM_FRONT) begin
                            tgt_x = '0;
                        end else if (r_func == bile_pkg::FN_RM_BACK) begin
                            tgt_x = cnt_x - XW'(1);
                        end else begin
                            tgt_x = pos_x;
                        end
                        if (tgt_x < cnt_x) begin
                            n_ok_w = 1'b1;
                            n_idx  = CW'(tgt_x);
                            // hold the last live index; it is the count after removal
                            n_tgt  = r_count - CW'(1);
                            if (tgt_x + XW'(1) < cnt_x) begin
                                n_state = bile_pkg::S_RD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    bile_pkg::FN_SEARCH: begin
                        n_idx     = '0;
                        n_found_w = r_count;
                        if (r_count != '0) begin
                            n_state = bile_pkg::S_RD;
                        end
                    end
                    bile_pkg::FN_SELECT: begin
                        if (r_count != '0) begin
                            if (pos_x < cnt_x) begin
                                n_idx  = CW'(pos_x);
                                n_ok_w = 1'b1;
                            end else begin
                                n_idx = r_count - CW'(1);
                            end
                            n_state = bile_pkg::S_RD;
                        end
                    end
                    bile_pkg::FN_REPLACE: begin
                        if (pos_x < cnt_x) begin
                            n_idx   = CW'(pos_x);
                            n_ok_w  = 1'b1;
                            n_state = bile_pkg::S_PUT;
                        end
                    end
                    default: begin
                        n_state = bile_pkg::S_DONE;
                    end
                endcase
            end
            bile_pkg::S_RD: begin
                if (r_func == bile_pkg::FN_SEARCH) begin
                    n_state = bile_pkg::S_CMP;
                end else if (r_func == bile_pkg::FN_SELECT) begin
                    n_state = bile_pkg::S_SEL;
                end else begin
                    n_state = bile_pkg::S_WR;
                end
            end
            bile_pkg::S_WR: begin
                ram_we = 1'b1;
                n_idx  = idx_step;
                if (is_ins) begin
                    n_state = (idx_step == r_tgt) ? bile_pkg::S_PUT : bile_pkg::S_RD;
                end else if (idx_step == r_tgt) begin
                    n_count = r_tgt;
                    n_state = bile_pkg::S_DONE;
                end else begin
                    n_state = bile_pkg::S_RD;
                end
            end
            bile_pkg::S_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = r_val;
                if (is_ins) begin
                    n_count = r_count + CW'(1);
                    n_ok_w  = 1'b1;
                end
                n_state = bile_pkg::S_DONE;
            end
            bile_pkg::S_CMP: begin
                if (ram_rdata == r_val) begin
                    n_found_w = r_idx;
                    n_ok_w    = 1'b1;
                    n_state   = bile_pkg::S_DONE;
                end else if (idx_step == r_count) begin
                    n_state = bile_pkg::S_DONE;
                end else begin
                    n_idx   = idx_step;
                    n_state = bile_pkg::S_RD;
                end
            end
            bile_pkg::S_SEL: begin
                n_rd_w  = rd_ext[VW-1:0];
                n_state = bile_pkg::S_DONE;
            end
            bile_pkg::S_DONE: begin
                // hand over only once the result register is free
                if (!r_o_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = bile_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bile_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bile_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_tgt     <= n_tgt;
        r_ok_w    <= n_ok_w;
        r_found_w <= n_found_w;
        r_rd_w    <= n_rd_w;
        if (out_load) begin
            r_o_ok    <= r_ok_w;
            r_o_found <= PW'(r_found_w);
            r_o_rd    <= r_rd_w;
            r_o_count <= PW'(r_count);
            r_o_empty <= (r_count == '0);
            r_o_full  <= (r_count == CAP);
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_ok          = r_o_ok;
    assign o_found_index = r_o_found;
    assign o_read_value  = r_o_rd;
    assign o_entry_count = r_o_count;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;

    `BILE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `BILE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP)
    `BILE_ASSERT_NXT(a_count_step, i_clk, i_rst_n, 1'b1,
                     (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1))
                     || (r_count == $past(r_count) - CW'(1)))
    `BILE_ASSERT_IMP(a_write_states, i_clk, i_rst_n, ram_we,
                     (r_state == bile_pkg::S_WR) || (r_state == bile_pkg::S_PUT))
    `BILE_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, $rose(r_o_valid),
                     $past(r_state) == bile_pkg::S_DONE)

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

localparam logic [bile_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 4'd9;
localparam logic [bile_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 4'd15;
localparam int unsigned LIST_CAP  = bile_pkg::CAPACITY_MAX_DEF;
localparam int unsigned POS_MAX   = (1 << bile_pkg::POS_W) - 1;
localparam int unsigned MAX_SHOWN = 10;

typedef struct packed {
    logic                       ok;
    logic [bile_pkg::POS_W-1:0] found_index;
    logic [bile_pkg::VAL_W-1:0] read_value;
    logic [bile_pkg::POS_W-1:0] entry_count;
    logic                       is_empty;
    logic                       is_full;
} t_list_reply;

class list_tracker;
    logic [bile_pkg::VAL_W-1:0] slots [LIST_CAP];
    int unsigned      fill;
    t_list_reply      awaiting [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      refused;
    int unsigned      full_seen;
    int unsigned      empty_seen;

    function bit insert_at(int unsigned p, logic [bile_pkg::VAL_W-1:0] v);
        int unsigned i;
        if (fill >= LIST_CAP || p > fill) return 1'b0;
        for (i = fill; i > p; i--) slots[i] = slots[i-1];
        slots[p] = v;
        fill++;
        return 1'b1;
    endfunction

    function bit remove_at(int unsigned p);
        int unsigned i;
        if (p >= fill) return 1'b0;
        for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
        fill--;
        return 1'b1;
    endfunction

    // Apply one accepted request to the shadow list and queue its reply.
    function void take_request(logic [bile_pkg::FUNC_W-1:0] fn,
                               logic [bile_pkg::VAL_W-1:0] v,
                               logic [bile_pkg::POS_W-1:0] pos);
        t_list_reply r;
        int unsigned p;
        int unsigned i;
        bit          hit;
        r   = '0;
        p   = pos;
        hit = 1'b0;
        case (fn)
            bile_pkg::FN_INS_FRONT: r.ok = insert_at(0, v);
            bile_pkg::FN_INS_BACK:  r.ok = insert_at(fill, v);
            bile_pkg::FN_INS_AT:    r.ok = insert_at(p, v);
            bile_pkg::FN_RM_FRONT:  r.ok = remove_at(0);
            bile_pkg::FN_RM_BACK:   r.ok = (fill > 0) ? remove_at(fill - 1) : 1'b0;
            bile_pkg::FN_RM_AT:     r.ok = remove_at(p);
            bile_pkg::FN_SEARCH: begin
                r.found_index = fill[bile_pkg::POS_W-1:0];
                for (i = 0; i < fill && !hit; i++) begin
                    if (slots[i] == v) begin
                        r.found_index = i[bile_pkg::POS_W-1:0];
                        r.ok = 1'b1;
                        hit = 1'b1;
                    end
                end
            end
            bile_pkg::FN_SELECT: begin
                if (fill > 0) begin
                    if (p < fill) begin
                        r.read_value = slots[p];
                        r.ok = 1'b1;
                    end else begin
                        // past the end reads the last entry
                        r.read_value = slots[fill - 1];
                    end
                end
            end
            bile_pkg::FN_REPLACE: begin
                if (p < fill) begin
                    slots[p] = v;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.entry_count = fill[bile_pkg::POS_W-1:0];
        r.is_empty    = (fill == 0);
        r.is_full     = (fill == LIST_CAP);
        if (!r.ok) refused++;
        if (r.is_full) full_seen++;
        if (r.is_empty) empty_seen++;
        awaiting.push_back(r);
    endfunction

    function string show(t_list_reply r);
        return $sformatf("ok=%0b idx=%0d val=%h cnt=%0d empty=%0b full=%0b",
                         r.ok, r.found_index, r.read_value, r.entry_count,
                         r.is_empty, r.is_full);
    endfunction

    function void check_reply(t_list_reply got);
        t_list_reply want;
        if (awaiting.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("reply with nothing outstanding: %s", show(got));
            return;
        end
        want = awaiting.pop_front();
        checked++;
        if (got.ok !== want.ok || got.found_index !== want.found_index ||
            got.read_value !== want.read_value || got.entry_count !== want.entry_count ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("reply %0d mismatch: expected %s, got %s",
                         checked, show(want), show(got));
        end
    endfunction
endclass

module tb;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned EPISODE_CAP  = 200;
    localparam int unsigned EPISODE_TAIL = 8;
    localparam int unsigned CHURN_ITEMS  = 25;
    localparam int FW = bile_pkg::FUNC_W;
    localparam int VW = bile_pkg::VAL_W;
    localparam int PW = bile_pkg::POS_W;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} t_traffic_mix;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [FW-1:0]        i_func       = '0;
    logic signed [VW-1:0] i_item_value = '0;
    logic [PW-1:0]        i_position   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_ok;
    logic [PW-1:0]        o_found_index;
    logic signed [VW-1:0] o_read_value;
    logic [PW-1:0]        o_entry_count;
    logic                 o_is_empty;
    logic                 o_is_full;

    list_tracker sb = new();
    t_list_reply sampled_reply;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned stall_run      = 0;
    int          send_idle_tab [4] = '{0, 51, 0, 12};
    int          recv_stall_tab [4] = '{0, 0, 51, 12};

    bounded_indexed_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_item_value  (i_item_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check result beats and watch for a hung handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_run = 0;
            else
                stall_run++;
            if (o_out_valid && i_out_ready) begin
                sampled_reply.ok          = o_ok;
                sampled_reply.found_index = o_found_index;
                sampled_reply.read_value  = o_read_value;
                sampled_reply.entry_count = o_entry_count;
                sampled_reply.is_empty    = o_is_empty;
                sampled_reply.is_full     = o_is_full;
                sb.check_reply(sampled_reply);
            end
            if (stall_run >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles, %0d replies outstanding",
                         stall_run, sb.awaiting.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [FW-1:0] fn, input logic [VW-1:0] v,
                             input logic [PW-1:0] p);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_item_value <= v;
        i_position   <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_request(fn, v, p);
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        while (sb.awaiting.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input t_traffic_mix mix);
        int unsigned   f;
        int            roll;
        int            ins_pct;
        int            rm_pct;
        logic [FW-1:0] fn;
        logic [VW-1:0] v;
        logic [PW-1:0] p;
        f = sb.fill;
        case (mix)
            MIX_GROW:   begin ins_pct = 80; rm_pct = 8;  end
            MIX_SHRINK: begin ins_pct = 8;  rm_pct = 80; end
            default:    begin ins_pct = 30; rm_pct = 30; end
        endcase
        roll = $urandom_range(99);
        if (roll < 3)
            fn = FW'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
        else if (roll < 3 + ins_pct)
            fn = bile_pkg::FN_INS_FRONT + FW'($urandom_range(2));
        else if (roll < 3 + ins_pct + rm_pct)
            fn = bile_pkg::FN_RM_FRONT + FW'($urandom_range(2));
        else
            fn = bile_pkg::FN_SEARCH + FW'($urandom_range(2));
        // mostly legal positions, some anywhere in the field
        if ($urandom_range(99) < 85)
            p = (fn == bile_pkg::FN_INS_AT) ? PW'($urandom_range(f))
                                            : ((f > 0) ? PW'($urandom_range(f - 1)) : '0);
        else
            p = PW'($urandom_range(POS_MAX));
        roll = $urandom_range(99);
        if (f > 0 && roll < ((fn == bile_pkg::FN_SEARCH) ? 60 : 30)) begin
            v = sb.slots[$urandom_range(f - 1)];
        end else if (roll >= 90) begin
            case ($urandom_range(3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom();
        end
        send_beat(fn, v, p);
    endtask

    // Grow and shrink run until the list hits its bound, then a few more beats.
    task automatic run_episode(input t_traffic_mix mix, input int unsigned extra);
        int unsigned n;
        int unsigned past;
        n    = 0;
        past = 0;
        while (past < extra && n < EPISODE_CAP) begin
            send_random(mix);
            n++;
            if (mix == MIX_CHURN || (mix == MIX_GROW && sb.fill == LIST_CAP) ||
                (mix == MIX_SHRINK && sb.fill == 0))
                past++;
        end
        wait_for_replies();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every read, remove and replace is refused
        send_beat(bile_pkg::FN_SELECT, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_RM_FRONT, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_RM_BACK, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_RM_AT, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_REPLACE, 32'h1111_2222, 7'd0);
        send_beat(bile_pkg::FN_SEARCH, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_INS_AT, 32'h0BAD_0BAD, 7'd1);
        // build the list through each insert form, including both ends of ins_at
        send_beat(bile_pkg::FN_INS_AT, 32'h8000_0000, 7'd0);
        send_beat(bile_pkg::FN_INS_BACK, 32'h7FFF_FFFF, 7'd0);
        send_beat(bile_pkg::FN_INS_FRONT, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_INS_AT, 32'hFFFF_FFFF, 7'd3);
        send_beat(bile_pkg::FN_INS_AT, 32'h1234_5678, 7'd2);
        send_beat(bile_pkg::FN_SEARCH, 32'h7FFF_FFFF, 7'd0);
        send_beat(bile_pkg::FN_SEARCH, 32'h0000_0055, 7'd0);
        send_beat(bile_pkg::FN_SELECT, 32'h0, 7'd1);
        send_beat(bile_pkg::FN_SELECT, 32'h0, 7'(POS_MAX));
        send_beat(bile_pkg::FN_REPLACE, 32'hA5A5_A5A5, 7'd4);
        send_beat(bile_pkg::FN_REPLACE, 32'h5A5A_5A5A, 7'd5);
        send_beat(bile_pkg::FN_RM_AT, 32'h0, 7'd5);
        send_beat(bile_pkg::FN_RM_AT, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_RM_AT, 32'h0, 7'd1);
        send_beat(bile_pkg::FN_RM_BACK, 32'h0, 7'd0);
        send_beat(bile_pkg::FN_RM_FRONT, 32'h0, 7'd0);
        send_beat(FUNC_UNUSED_FIRST, 32'h0, 7'd0);
        send_beat(FUNC_UNUSED_LAST, 32'hFFFF_FFFF, 7'(POS_MAX));
        wait_for_replies();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_idle_tab[ph];
            recv_stall_pct = recv_stall_tab[ph];
            // back up the block behind a stalled receiver
            if (ph == 0) hold_requests++;
            run_episode((ph % 2 == 0) ? MIX_GROW : MIX_SHRINK, EPISODE_TAIL);
            run_episode(MIX_CHURN, CHURN_ITEMS);
        end

        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.awaiting.size() != 0) sb.errors++;
        $display("Checked %0d replies: %0d with ok low, %0d at full, %0d at empty.",
                 sb.checked, sb.refused, sb.full_seen, sb.empty_seen);
        $display("Traffic mixes: free flow, sparse sender, stalling receiver, both; long hold.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/bile_pkg.sv
rtl/bile_ram.sv
rtl/bounded_indexed_list_engine.sv
bench/tb.sv
